>>> rtl/fcrc_pkg.sv
package fcrc_pkg;

    // Field and register widths
    localparam int COORD_W = 10;
    localparam int GRID_W  = 11;
    localparam int CFG_W   = 8;
    localparam int LEVEL_W = 8;
    localparam int IDX_W   = 20;
    localparam int LIM_W   = 13;

    // Largest grid the geometry check accepts
    localparam logic [LIM_W-1:0] MAX_COLS = 13'd1024;
    localparam logic [LIM_W-1:0] MAX_ROWS = 13'd1024;

    // Marker luminance and default lattice pitch
    localparam logic [LEVEL_W-1:0] LEVEL_BRIGHT  = 8'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_DARK    = 8'd0;
    localparam logic [CFG_W-1:0]   DEFAULT_PITCH = 8'd16;

    // Register reset values
    localparam logic [GRID_W-1:0] RST_GRID_COLUMNS = 11'd64;
    localparam logic [GRID_W-1:0] RST_GRID_ROWS    = 11'd64;
    localparam logic [CFG_W-1:0]  RST_MARKER_CELLS = 8'd6;
    localparam logic [CFG_W-1:0]  RST_GUARD_CELLS  = 8'd1;
    localparam logic [CFG_W-1:0]  RST_RING_CELLS   = 8'd1;
    localparam logic [CFG_W-1:0]  RST_HEADER_ROWS  = 8'd2;
    localparam logic [CFG_W-1:0]  RST_LATTICE      = 8'd16;

    typedef enum logic [2:0] {
        ROLE_PAYLOAD,
        ROLE_MARKER,
        ROLE_GUARD,
        ROLE_BOUNDARY,
        ROLE_TIMING,
        ROLE_HEADER,
        ROLE_PILOT,
        ROLE_COLOUR
    } t_role;

    typedef enum logic [2:0] {
        CFG_GRID_COLUMNS,
        CFG_GRID_ROWS,
        CFG_MARKER_CELLS,
        CFG_GUARD_CELLS,
        CFG_RING_CELLS,
        CFG_HEADER_ROWS,
        CFG_LATTICE_PITCH
    } t_cfg_idx;

endpackage

>>> rtl/fcrc_in_if.sv
interface fcrc_in_if;
    import fcrc_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] cell_col;
    logic [COORD_W-1:0] cell_row;

    modport source (output valid, output cell_col, output cell_row, input ready);
    modport sink   (input valid, input cell_col, input cell_row, output ready);
endinterface

>>> rtl/fcrc_out_if.sv
interface fcrc_out_if;
    import fcrc_pkg::*;

    logic               valid;
    logic               ready;
    t_role              cell_role;
    logic [LEVEL_W-1:0] marker_level;
    logic [IDX_W-1:0]   raster_index;
    logic               outside_grid;
    logic               geometry_invalid;

    modport source (
        output valid, output cell_role, output marker_level, output raster_index,
        output outside_grid, output geometry_invalid, input ready
    );
    modport sink (
        input valid, input cell_role, input marker_level, input raster_index,
        input outside_grid, input geometry_invalid, output ready
    );
endinterface

>>> rtl/frame_cell_role_classifier_top.sv
// Channel   Dir  Handshake      Word
// i_cell    in   valid/ready    cell_col, cell_row
// o_cell    out  valid/ready    cell_role, marker_level, raster_index, outside_grid,
//                               geometry_invalid
// i_cfg_*   in   write enable   register index, write data (no read-back)
//
// One word per clock while the output is not stalled, over twelve register stages: an
// entry stage, ten steps of the restoring divider that reduces column and row by the
// lattice pitch (one quotient bit per stage), and a final pilot stage. Region compares and
// the raster multiply ride alongside the first two divider steps.
// Reset clears all valid bits and reloads the geometry registers.
// A stall backs up through a per-stage ready chain; empty stages keep filling.
module frame_cell_role_classifier_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [2:0]                  i_cfg_idx,
    input  logic [fcrc_pkg::GRID_W-1:0] i_cfg_data,
    fcrc_in_if.sink                     i_cell,
    fcrc_out_if.source                  o_cell
);
    import fcrc_pkg::*;

    localparam int NSTG = COORD_W + 2;
    localparam int LAST = NSTG - 1;
    localparam int W    = GRID_W + 1;

    typedef struct packed {
        logic [COORD_W-1:0] c;
        logic [COORD_W-1:0] r;
        logic               outside;
        logic               mk;
        logic               gdc;
        logic               ring;
        logic               inner;
        logic               tim;
        logic               hdr;
        logic               hgd;
        logic               left;
        logic               top;
        logic [GRID_W-1:0]  lc;
        logic [GRID_W-1:0]  lr;
        logic [IDX_W-1:0]   idx;
        t_role              role;
        logic [LEVEL_W-1:0] level;
        logic [COORD_W-1:0] cq;
        logic [COORD_W-1:0] rq;
        logic [CFG_W-1:0]   crem;
        logic [CFG_W-1:0]   rrem;
    } t_item;

    // Geometry registers
    logic [GRID_W-1:0] r_cols, r_rows;
    logic [CFG_W-1:0]  r_mark, r_guard, r_ring, r_hbr, r_lattice;

    // Values derived from the geometry
    logic [CFG_W:0]   r_mg, n_mg;
    logic [W-1:0]     r_hs, r_he, r_heg, n_hs, n_he, n_heg;
    logic [CFG_W-1:0] r_pitch, n_pitch;
    logic             r_geo_bad, n_geo_bad;
    logic [W-1:0]     w_used;

    // Pipeline
    t_item            r_stg [NSTG];
    t_item            n_stg [NSTG];
    logic [NSTG-1:0]  r_vld;
    logic [NSTG-1:0]  w_rdy;

    // Divider step signals
    logic [CFG_W:0]   w_ctrial [COORD_W];
    logic [CFG_W:0]   w_rtrial [COORD_W];
    logic [COORD_W-1:0] w_cge, w_rge;

    // Stage one operands, widened for exact compares
    logic [W-1:0] w_cx, w_rx, w_colsx, w_rowsx, w_mx, w_mgx, w_gx, w_bwx;

    // Stage two and final stage temporaries
    logic [GRID_W-1:0]  w_d;
    logic               w_even;
    logic [LEVEL_W-1:0] w_level;
    t_role              w_role2;
    logic [CFG_W-1:0]   w_half;
    logic               w_pilot;
    logic               w_colour;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols    <= RST_GRID_COLUMNS;
            r_rows    <= RST_GRID_ROWS;
            r_mark    <= RST_MARKER_CELLS;
            r_guard   <= RST_GUARD_CELLS;
            r_ring    <= RST_RING_CELLS;
            r_hbr     <= RST_HEADER_ROWS;
            r_lattice <= RST_LATTICE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GRID_COLUMNS:  r_cols    <= i_cfg_data;
                CFG_GRID_ROWS:     r_rows    <= i_cfg_data;
                CFG_MARKER_CELLS:  r_mark    <= i_cfg_data[CFG_W-1:0];
                CFG_GUARD_CELLS:   r_guard   <= i_cfg_data[CFG_W-1:0];
                CFG_RING_CELLS:    r_ring    <= i_cfg_data[CFG_W-1:0];
                CFG_HEADER_ROWS:   r_hbr     <= i_cfg_data[CFG_W-1:0];
                CFG_LATTICE_PITCH: r_lattice <= i_cfg_data[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Derive header window, pitch and geometry check
    always_comb begin
        n_mg    = {1'b0, r_mark} + {1'b0, r_guard};
        n_hs    = (r_rows > GRID_W'(r_hbr)) ? W'((r_rows - GRID_W'(r_hbr)) >> 1) : '0;
        n_he    = n_hs + W'(r_hbr);
        n_heg   = n_he + W'(r_guard);
        n_pitch = (r_lattice == '0) ? DEFAULT_PITCH : r_lattice;
        w_used  = W'({n_mg, 1'b0});
        n_geo_bad = (r_cols == '0) || (r_rows == '0)
                 || (LIM_W'(r_cols) > MAX_COLS) || (LIM_W'(r_rows) > MAX_ROWS)
                 || (w_used + W'(4) >= W'(r_cols))
                 || (w_used + W'(r_hbr) + W'(4) >= W'(r_rows));
    end

    always_ff @(posedge i_clk) begin
        r_mg      <= n_mg;
        r_hs      <= n_hs;
        r_he      <= n_he;
        r_heg     <= n_heg;
        r_pitch   <= n_pitch;
        r_geo_bad <= n_geo_bad;
    end

    // Ready chain, last stage first
    always_comb begin
        w_rdy[LAST] = !r_vld[LAST] || o_cell.ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign i_cell.ready = w_rdy[0] && i_rst_n;

    // Restoring divider steps, one quotient bit per stage
    always_comb begin
        for (int j = 0; j < COORD_W; j++) begin
            w_ctrial[j] = {r_stg[j].crem, r_stg[j].c[COORD_W-1-j]};
            w_rtrial[j] = {r_stg[j].rrem, r_stg[j].r[COORD_W-1-j]};
            w_cge[j]    = w_ctrial[j] >= {1'b0, r_pitch};
            w_rge[j]    = w_rtrial[j] >= {1'b0, r_pitch};
        end
    end

    // Stage one operands
    always_comb begin
        w_cx    = W'(r_stg[0].c);
        w_rx    = W'(r_stg[0].r);
        w_colsx = W'(r_cols);
        w_rowsx = W'(r_rows);
        w_mx    = W'(r_mark);
        w_mgx   = W'(r_mg);
        w_gx    = W'(r_guard);
        w_bwx   = W'(r_ring);
    end

    // Stage two: resolve the role up to the header guard, and the marker level
    always_comb begin
        w_d    = (r_stg[1].lc < r_stg[1].lr) ? r_stg[1].lc : r_stg[1].lr;
        w_even = !(r_stg[1].lc[0] ^ r_stg[1].lr[0]);
        if (w_d == '0) begin
            w_level = LEVEL_BRIGHT;
        end else if (w_d == GRID_W'(1)) begin
            w_level = LEVEL_DARK;
        end else if (r_stg[1].left && r_stg[1].top) begin
            w_level = LEVEL_BRIGHT;
        end else if (r_stg[1].top) begin
            w_level = LEVEL_DARK;
        end else if (r_stg[1].left) begin
            w_level = w_even ? LEVEL_BRIGHT : LEVEL_DARK;
        end else begin
            w_level = w_even ? LEVEL_DARK : LEVEL_BRIGHT;
        end

        if (r_stg[1].mk) begin
            w_role2 = ROLE_MARKER;
        end else if (r_stg[1].gdc) begin
            w_role2 = ROLE_GUARD;
        end else begin
            w_role2 = ROLE_PAYLOAD;
        end
        if (r_stg[1].ring && w_role2 != ROLE_MARKER) begin
            w_role2 = ROLE_BOUNDARY;
        end
        if (r_stg[1].tim && r_stg[1].inner && w_role2 == ROLE_PAYLOAD) begin
            w_role2 = ROLE_TIMING;
        end
        if (r_stg[1].inner && r_stg[1].hdr) begin
            w_role2 = ROLE_HEADER;
        end
        if (r_stg[1].inner && r_stg[1].hgd && w_role2 == ROLE_PAYLOAD) begin
            w_role2 = ROLE_GUARD;
        end
    end

    // Final stage: pilot lattice hit when both remainders sit at half pitch
    always_comb begin
        w_half   = {1'b0, r_pitch[CFG_W-1:1]};
        w_pilot  = (r_stg[LAST-1].crem == w_half) && (r_stg[LAST-1].rrem == w_half);
        w_colour = (r_stg[LAST-1].cq[1:0] + {r_stg[LAST-1].rq[0], 1'b0}) == 2'b00;
    end

    // Next value of every stage
    always_comb begin
        n_stg[0]   = '0;
        n_stg[0].c = i_cell.cell_col;
        n_stg[0].r = i_cell.cell_row;
        for (int k = 1; k < NSTG; k++) begin
            n_stg[k] = r_stg[k-1];
        end

        // Advance the divider
        for (int j = 0; j < COORD_W; j++) begin
            n_stg[j+1].cq[COORD_W-1-j] = w_cge[j];
            n_stg[j+1].rq[COORD_W-1-j] = w_rge[j];
            n_stg[j+1].crem = w_cge[j] ? CFG_W'(w_ctrial[j] - {1'b0, r_pitch})
                                       : w_ctrial[j][CFG_W-1:0];
            n_stg[j+1].rrem = w_rge[j] ? CFG_W'(w_rtrial[j] - {1'b0, r_pitch})
                                       : w_rtrial[j][CFG_W-1:0];
        end

        // Region compares and raster product
        n_stg[1].outside = (w_cx >= w_colsx) || (w_rx >= w_rowsx);
        n_stg[1].mk   = ((w_cx < w_mx) || (w_cx + w_mx >= w_colsx))
                     && ((w_rx < w_mx) || (w_rx + w_mx >= w_rowsx));
        n_stg[1].gdc  = ((w_cx < w_mgx) || (w_cx + w_mgx >= w_colsx))
                     && ((w_rx < w_mgx) || (w_rx + w_mgx >= w_rowsx));
        n_stg[1].ring = (w_cx < w_bwx) || (w_cx + w_bwx >= w_colsx)
                     || (w_rx < w_bwx) || (w_rx + w_bwx >= w_rowsx);
        n_stg[1].inner = (w_cx >= w_mgx) && (w_cx + w_mgx < w_colsx);
        n_stg[1].tim  = (w_rowsx > W'({r_ring, 1'b0}))
                     && ((w_rx == w_bwx) || (w_rx + w_bwx + W'(1) == w_rowsx));
        n_stg[1].hdr  = (w_rx >= r_hs) && (w_rx < r_he);
        n_stg[1].hgd  = ((w_rx < r_hs) && (w_rx + w_gx >= r_hs))
                     || ((w_rx >= r_he) && (w_rx < r_heg));
        n_stg[1].left = w_cx < w_mx;
        n_stg[1].top  = w_rx < w_mx;
        n_stg[1].lc   = (w_cx < w_mx) ? GRID_W'(r_stg[0].c)
                                      : r_cols - GRID_W'(1) - GRID_W'(r_stg[0].c);
        n_stg[1].lr   = (w_rx < w_mx) ? GRID_W'(r_stg[0].r)
                                      : r_rows - GRID_W'(1) - GRID_W'(r_stg[0].r);
        n_stg[1].idx  = IDX_W'({{GRID_W{1'b0}}, r_stg[0].r} * {{COORD_W{1'b0}}, r_cols});

        // Role, level and raster index
        n_stg[2].role  = w_role2;
        n_stg[2].level = w_level;
        n_stg[2].idx   = r_stg[1].idx + IDX_W'(r_stg[1].c);

        // Pilot lattice and outside-grid blanking
        if (r_stg[LAST-1].role == ROLE_PAYLOAD && w_pilot) begin
            n_stg[LAST].role = w_colour ? ROLE_COLOUR : ROLE_PILOT;
        end
        if (n_stg[LAST].role != ROLE_MARKER) begin
            n_stg[LAST].level = LEVEL_DARK;
        end
        if (r_stg[LAST-1].outside) begin
            n_stg[LAST].role  = ROLE_PAYLOAD;
            n_stg[LAST].level = LEVEL_DARK;
            n_stg[LAST].idx   = '0;
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_cell.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Advance stage words
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (w_rdy[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    // Drive the result word
    assign o_cell.valid            = r_vld[LAST];
    assign o_cell.cell_role        = r_stg[LAST].role;
    assign o_cell.marker_level     = r_stg[LAST].level;
    assign o_cell.raster_index     = r_stg[LAST].idx;
    assign o_cell.outside_grid     = r_stg[LAST].outside;
    assign o_cell.geometry_invalid = r_geo_bad;

endmodule

>>> rtl/fcrc_checker.sv
module fcrc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input fcrc_pkg::t_role              i_role,
    input logic [fcrc_pkg::LEVEL_W-1:0] i_level,
    input logic [fcrc_pkg::IDX_W-1:0]   i_idx,
    input logic                         i_outside
);
    import fcrc_pkg::*;

    // Hold a stalled result word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_role)
            && $stable(i_level) && $stable(i_idx) && $stable(i_outside))
        else $error("stalled result word changed");

    // Drop everything in flight on reset
    a_flush: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // Only marker cells carry luminance, and only full or zero
    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_level == LEVEL_DARK)
            || (i_level == LEVEL_BRIGHT && i_role == ROLE_MARKER))
        else $error("marker level on a non-marker cell");

    // Blank role, level and index outside the grid
    a_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_outside |-> i_role == ROLE_PAYLOAD
            && i_level == LEVEL_DARK && i_idx == '0)
        else $error("outside cell not blanked");

endmodule

bind frame_cell_role_classifier_top fcrc_checker u_fcrc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_cell.valid),
    .i_out_ready (o_cell.ready),
    .i_role      (o_cell.cell_role),
    .i_level     (o_cell.marker_level),
    .i_idx       (o_cell.raster_index),
    .i_outside   (o_cell.outside_grid)
);

>>> dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fcrc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 24;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int FRAME_SLACK    = 4;
    localparam int COLOUR_PERIOD  = 4;
    localparam int RANDOM_FRAMES  = 30;
    localparam int CELLS_PER_FRAME = 52;

    // Index 7 has no register behind it
    localparam logic [2:0] CFG_UNUSED_IDX = 3'd7;

    typedef struct {
        logic [GRID_W-1:0] cols;
        logic [GRID_W-1:0] rows;
        logic [CFG_W-1:0]  marker;
        logic [CFG_W-1:0]  guard;
        logic [CFG_W-1:0]  ring;
        logic [CFG_W-1:0]  header;
        logic [CFG_W-1:0]  pitch;
    } t_geometry;

    typedef struct {
        t_role              role;
        logic [LEVEL_W-1:0] level;
        logic [IDX_W-1:0]   index;
        logic               outside;
        logic               bad;
    } t_cell_word;

    localparam t_geometry RESET_GEO = '{
        cols: RST_GRID_COLUMNS, rows: RST_GRID_ROWS, marker: RST_MARKER_CELLS,
        guard: RST_GUARD_CELLS, ring: RST_RING_CELLS, header: RST_HEADER_ROWS,
        pitch: RST_LATTICE
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [2:0]        i_cfg_idx;
    logic [GRID_W-1:0] i_cfg_data;

    fcrc_in_if  cell_in();
    fcrc_out_if cell_out();

    frame_cell_role_classifier_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cell     (cell_in),
        .o_cell     (cell_out)
    );

    t_geometry  frame_geo;
    t_cell_word expected_words[$];
    int         fail_count;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         holdoff_request;
    int         holdoff_left;
    int         quiet_cycles;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Classify one cell against the current frame geometry
    function automatic t_cell_word classify_cell(t_geometry g, int unsigned c,
                                                 int unsigned r);
        int unsigned cols, rows, m, gd, bw, hb, mg, used, hs, he, p, half;
        int unsigned lc, lr, depth, idx;
        logic        inner, left, top, even;
        t_role       role;
        t_cell_word  w;

        cols = 32'(g.cols);
        rows = 32'(g.rows);
        m    = 32'(g.marker);
        gd   = 32'(g.guard);
        bw   = 32'(g.ring);
        hb   = 32'(g.header);
        mg   = m + gd;
        used = 2 * mg;

        w.bad = (cols == 0) || (rows == 0) || (cols > MAX_COLS) || (rows > MAX_ROWS) ||
                (used + FRAME_SLACK >= cols) || (used + hb + FRAME_SLACK >= rows);
        w.outside = (c >= cols) || (r >= rows);
        w.role    = ROLE_PAYLOAD;
        w.level   = LEVEL_DARK;
        w.index   = '0;
        if (w.outside)
            return w;

        // Corner markers and their guard
        role  = ROLE_PAYLOAD;
        inner = (c >= mg) && (c + mg < cols);
        if (((c < m) || (c + m >= cols)) && ((r < m) || (r + m >= rows)))
            role = ROLE_MARKER;
        else if (((c < mg) || (c + mg >= cols)) && ((r < mg) || (r + mg >= rows)))
            role = ROLE_GUARD;

        // Boundary ring leaves markers alone
        if (((c < bw) || (c + bw >= cols) || (r < bw) || (r + bw >= rows)) &&
            role != ROLE_MARKER)
            role = ROLE_BOUNDARY;

        // Timing tracks just inside the ring
        if (rows > 2 * bw && inner && role == ROLE_PAYLOAD &&
            (r == bw || r + 1 + bw == rows))
            role = ROLE_TIMING;

        // Header band, then guard rows over payload around it
        hs = (rows > hb) ? (rows - hb) / 2 : 0;
        he = hs + hb;
        if (inner && r >= hs && r < he)
            role = ROLE_HEADER;
        if (inner && role == ROLE_PAYLOAD &&
            ((r < hs && r + gd >= hs) || (r >= he && r < he + gd)))
            role = ROLE_GUARD;

        // Pilot lattice; zero pitch falls back to the default
        p    = (g.pitch == '0) ? 32'(DEFAULT_PITCH) : 32'(g.pitch);
        half = p / 2;
        if (role == ROLE_PAYLOAD && r >= half && c >= half &&
            (r - half) % p == 0 && (c - half) % p == 0)
            role = (((c / p) + 2 * (r / p)) % COLOUR_PERIOD == 0) ? ROLE_COLOUR : ROLE_PILOT;

        // Marker luminance: bright edge, dark separator, then corner pattern
        if (role == ROLE_MARKER) begin
            left  = c < m;
            top   = r < m;
            lc    = left ? c : cols - 1 - c;
            lr    = top ? r : rows - 1 - r;
            depth = (lc < lr) ? lc : lr;
            even  = ((lc + lr) % 2) == 0;
            if (depth == 0)
                w.level = LEVEL_BRIGHT;
            else if (depth == 1)
                w.level = LEVEL_DARK;
            else if (left && top)
                w.level = LEVEL_BRIGHT;
            else if (top)
                w.level = LEVEL_DARK;
            else if (left)
                w.level = even ? LEVEL_BRIGHT : LEVEL_DARK;
            else
                w.level = even ? LEVEL_DARK : LEVEL_BRIGHT;
        end

        idx     = r * cols + c;
        w.role  = role;
        w.index = idx[IDX_W-1:0];
        return w;
    endfunction

    function automatic t_geometry random_geometry();
        t_geometry g;
        if ($urandom_range(99) < 12) begin
            // Anything the registers can hold
            g.cols   = GRID_W'($urandom);
            g.rows   = GRID_W'($urandom);
            g.marker = CFG_W'($urandom);
            g.guard  = CFG_W'($urandom);
            g.ring   = CFG_W'($urandom);
            g.header = CFG_W'($urandom);
            g.pitch  = CFG_W'($urandom);
        end else begin
            g.cols   = GRID_W'(($urandom_range(9) == 0) ? $urandom_range(129, 1024)
                                                       : $urandom_range(16, 128));
            g.rows   = GRID_W'(($urandom_range(9) == 0) ? $urandom_range(129, 1024)
                                                       : $urandom_range(16, 128));
            g.marker = CFG_W'($urandom_range(0, 12));
            g.guard  = CFG_W'($urandom_range(0, 4));
            g.ring   = CFG_W'($urandom_range(0, 4));
            g.header = CFG_W'($urandom_range(0, 12));
            g.pitch  = CFG_W'($urandom_range(0, 40));
        end
        return g;
    endfunction

    // Drive one register; write enable stays high for a following write
    task automatic write_reg(logic [2:0] idx, logic [GRID_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
    endtask

    // Load a whole geometry; 8-bit registers get junk in the upper data bits
    task automatic apply_geometry(t_geometry g, bit poke_unused);
        write_reg(CFG_GRID_COLUMNS, g.cols);
        write_reg(CFG_GRID_ROWS, g.rows);
        write_reg(CFG_MARKER_CELLS, {3'($urandom), g.marker});
        write_reg(CFG_GUARD_CELLS, {3'($urandom), g.guard});
        write_reg(CFG_RING_CELLS, {3'($urandom), g.ring});
        write_reg(CFG_HEADER_ROWS, {3'($urandom), g.header});
        write_reg(CFG_LATTICE_PITCH, {3'($urandom), g.pitch});
        if (poke_unused)
            write_reg(CFG_UNUSED_IDX, '1);
        i_cfg_we  <= 1'b0;
        frame_geo = g;
    endtask

    // Offer one word and record its prediction once it is taken
    task automatic send_cell(int unsigned col, int unsigned row);
        logic [COORD_W-1:0] c_bits;
        logic [COORD_W-1:0] r_bits;
        c_bits = COORD_W'(col);
        r_bits = COORD_W'(row);
        // Idle a random number of cycles before offering
        while ($urandom_range(99) < send_idle_pct) begin
            cell_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        cell_in.valid    <= 1'b1;
        cell_in.cell_col <= c_bits;
        cell_in.cell_row <= r_bits;
        @(posedge i_clk);
        while (!cell_in.ready)
            @(posedge i_clk);
        expected_words.insert(expected_words.size(),
                              classify_cell(frame_geo, 32'(c_bits), 32'(r_bits)));
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every predicted word is back
    task automatic wait_drained();
        cell_in.valid <= 1'b0;
        while (expected_words.size() > 0)
            @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    // Mostly in-grid cells, some hugging the edges, some anywhere, some raster runs
    task automatic send_random_cells(int count);
        int          sent;
        int unsigned run, lim_c, lim_r, span_c, span_r, pick, col, row;
        sent  = 0;
        lim_c = (frame_geo.cols == '0) ? 1023 :
                ((frame_geo.cols > 11'd1024) ? 1023 : 32'(frame_geo.cols) - 1);
        lim_r = (frame_geo.rows == '0) ? 1023 :
                ((frame_geo.rows > 11'd1024) ? 1023 : 32'(frame_geo.rows) - 1);
        span_c = (lim_c < 3) ? lim_c : 3;
        span_r = (lim_r < 3) ? lim_r : 3;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                col = $urandom_range(0, 1023);
                row = $urandom_range(0, 1023);
            end else if (pick < 35) begin
                col = $urandom_range(1) ? $urandom_range(0, span_c)
                                        : lim_c - $urandom_range(0, span_c);
                row = $urandom_range(1) ? $urandom_range(0, lim_r)
                                        : lim_r - $urandom_range(0, span_r);
            end else begin
                col = $urandom_range(0, lim_c);
                row = $urandom_range(0, lim_r);
            end
            run = ($urandom_range(9) == 0) ? $urandom_range(4, 12) : 1;
            repeat (run) begin
                send_cell(col, row);
                col++;
                sent++;
            end
        end
    endtask

    // Every role at the reset geometry, plus cells off the grid
    task automatic test_default_frame();
        send_cell(0, 0);
        send_cell(1, 1);
        send_cell(2, 2);
        send_cell(61, 2);
        send_cell(2, 61);
        send_cell(61, 61);
        send_cell(3, 61);
        send_cell(6, 6);
        send_cell(0, 30);
        send_cell(10, 1);
        send_cell(10, 31);
        send_cell(10, 30);
        send_cell(8, 8);
        send_cell(24, 8);
        send_cell(20, 20);
        send_cell(64, 0);
        send_cell(1023, 1023);
        wait_drained();
    endtask

    // Register extremes: zero pitch, tall header, oversize grid, empty grid
    task automatic test_register_corners();
        t_geometry g;
        g       = RESET_GEO;
        g.pitch = '0;
        apply_geometry(g, 1'b1);
        send_cell(8, 8);
        wait_drained();

        g        = RESET_GEO;
        g.header = 8'd255;
        apply_geometry(g, 1'b0);
        send_cell(20, 0);
        wait_drained();

        // Raster index wraps past 20 bits
        g      = RESET_GEO;
        g.cols = 11'd2047;
        g.rows = 11'd2047;
        apply_geometry(g, 1'b0);
        send_cell(1023, 1023);
        wait_drained();

        g = '{cols: 11'd1024, rows: 11'd1024, marker: 8'd255, guard: 8'd255,
              ring: 8'd255, header: 8'd0, pitch: 8'd255};
        apply_geometry(g, 1'b0);
        send_cell(300, 300);
        wait_drained();

        g = '{cols: 11'd64, rows: 11'd64, marker: 8'd0, guard: 8'd0,
              ring: 8'd0, header: 8'd0, pitch: 8'd1};
        apply_geometry(g, 1'b0);
        send_cell(20, 20);
        wait_drained();

        g      = RESET_GEO;
        g.cols = 11'd0;
        g.rows = 11'd1024;
        apply_geometry(g, 1'b0);
        send_cell(0, 0);
        wait_drained();
    endtask

    // Back-to-back words with neither side idling
    task automatic test_full_rate();
        apply_geometry(RESET_GEO, 1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_cells(150);
        wait_drained();
        send_idle_pct = 23;
        recv_idle_pct = 23;
    endtask

    // Receiver stalls long enough that the pipe fills and input backs up
    task automatic test_output_holdoff();
        holdoff_request = HOLDOFF_CYCLES;
        send_random_cells(80);
        wait_drained();
    endtask

    // Sender stops until the pipe is empty, then carries on
    task automatic test_sender_pause();
        send_random_cells(40);
        wait_drained();
        send_random_cells(40);
        wait_drained();
    endtask

    task automatic test_random_frames();
        for (int frame = 0; frame < RANDOM_FRAMES; frame++) begin
            apply_geometry(random_geometry(), frame == 0);
            send_random_cells(CELLS_PER_FRAME);
            wait_drained();
        end
    endtask

    // Receiver: random stalls, or a counted hold-off when one is asked for
    always @(negedge i_clk) begin
        if (holdoff_request > 0) begin
            holdoff_left    = holdoff_request;
            holdoff_request = 0;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            cell_out.ready <= 1'b0;
        end else begin
            cell_out.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each returned word with the oldest prediction
    always @(posedge i_clk) begin
        t_cell_word want;
        if (cell_out.valid && cell_out.ready) begin
            if (expected_words.size() == 0) begin
                $error("unpredicted word: cell_role %0d raster_index %0d",
                       cell_out.cell_role, cell_out.raster_index);
                fail_count++;
            end else begin
                want = expected_words.pop_front();
                if (cell_out.cell_role !== want.role) begin
                    $error("cell_role: expected %0d, got %0d", want.role, cell_out.cell_role);
                    fail_count++;
                end
                if (cell_out.marker_level !== want.level) begin
                    $error("marker_level: expected %0d, got %0d",
                           want.level, cell_out.marker_level);
                    fail_count++;
                end
                if (cell_out.raster_index !== want.index) begin
                    $error("raster_index: expected %0d, got %0d",
                           want.index, cell_out.raster_index);
                    fail_count++;
                end
                if (cell_out.outside_grid !== want.outside) begin
                    $error("outside_grid: expected %0d, got %0d",
                           want.outside, cell_out.outside_grid);
                    fail_count++;
                end
                if (cell_out.geometry_invalid !== want.bad) begin
                    $error("geometry_invalid: expected %0d, got %0d",
                           want.bad, cell_out.geometry_invalid);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no word moves on either side for too long
    always @(posedge i_clk) begin
        if ((cell_in.valid && cell_in.ready) || (cell_out.valid && cell_out.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        cell_in.valid    = 1'b0;
        cell_in.cell_col = '0;
        cell_in.cell_row = '0;
        cell_out.ready   = 1'b0;
        fail_count       = 0;
        send_idle_pct    = 23;
        recv_idle_pct    = 23;
        holdoff_request  = 0;
        holdoff_left     = 0;
        quiet_cycles     = 0;
        frame_geo        = RESET_GEO;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_frame();
        test_register_corners();
        test_full_rate();
        test_output_holdoff();
        test_sender_pause();
        test_random_frames();

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && expected_words.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> frame_cell_role_classifier_top.f
rtl/fcrc_pkg.sv
rtl/fcrc_in_if.sv
rtl/fcrc_out_if.sv
rtl/frame_cell_role_classifier_top.sv
rtl/fcrc_checker.sv
dv/testbench.sv
